// ----- design/tjs_pkg.sv -----
package tjs_pkg;

  localparam logic [29:0] MinResetNs = 30'd999999999;
  localparam int unsigned DivSteps   = 64;
  localparam int unsigned StepW      = $clog2(DivSteps);

  localparam logic CmdClear  = 1'b0;
  localparam logic CmdSample = 1'b1;

  typedef struct packed {
    logic        command;
    logic [29:0] lateness_ns;
  } in_t;

  typedef struct packed {
    logic [29:0] latest_ns;
    logic [29:0] min_ns;
    logic [29:0] max_ns;
    logic [29:0] spread_ns;
    logic [29:0] mean_ns;
    logic [31:0] count;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_nz;
  } dp_sts_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

endpackage

// ----- design/tjs_dp.sv -----
module tjs_dp import tjs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output out_t    out_data_o
);

  logic [63:0] sum_q, sum_d;
  logic [31:0] count_q, count_d;
  logic [29:0] min_q, min_d;
  logic [29:0] max_q, max_d;
  logic [29:0] latest_q;
  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  out_t        out_q;

  logic [64:0] sum_add;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;
  logic        rem_ge;
  logic [29:0] mean;
  logic [29:0] spread;

  assign sum_add = {1'b0, sum_q} + {35'd0, in_data_i.lateness_ns};

  always_comb begin
    if (in_data_i.command == CmdClear) begin
      sum_d   = '0;
      count_d = '0;
      min_d   = MinResetNs;
      max_d   = '0;
    end else begin
      sum_d   = sum_add[64] ? '1 : sum_add[63:0];
      count_d = (count_q == '1) ? count_q : count_q + 32'd1;
      min_d   = (in_data_i.lateness_ns < min_q) ? in_data_i.lateness_ns : min_q;
      max_d   = (in_data_i.lateness_ns > max_q) ? in_data_i.lateness_ns : max_q;
    end
  end

  // restoring division, one quotient bit per step
  assign rem_sh   = {rem_q, quo_q[63]};
  assign rem_diff = rem_sh - {1'b0, count_q};
  assign rem_ge   = rem_sh >= {1'b0, count_q};

  always_comb begin
    if (cmd_i.accept) begin
      quo_d = sum_d;
      rem_d = '0;
    end else if (rem_ge) begin
      quo_d = {quo_q[62:0], 1'b1};
      rem_d = rem_diff[31:0];
    end else begin
      quo_d = {quo_q[62:0], 1'b0};
      rem_d = rem_sh[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      min_q   <= MinResetNs;
      max_q   <= '0;
    end else if (cmd_i.accept) begin
      sum_q   <= sum_d;
      count_q <= count_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      latest_q <= (in_data_i.command == CmdSample) ? in_data_i.lateness_ns : '0;
    end
    if (cmd_i.accept || cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      out_q <= '{latest_ns: latest_q, min_ns: min_q, max_ns: max_q,
                 spread_ns: spread, mean_ns: mean, count: count_q};
    end
  end

  // saturation can push the quotient past the maximum
  always_comb begin
    mean   = '0;
    spread = '0;
    if (count_q != '0) begin
      mean   = (quo_q > {34'd0, max_q}) ? max_q : quo_q[29:0];
      spread = (max_q >= min_q) ? max_q - min_q : '0;
    end
  end

  assign sts_o.count_nz = count_q != '0;
  assign out_data_o     = out_q;

  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= MinResetNs)
    else $error("minimum above reset value");

  a_empty_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (sum_q == '0 && max_q == '0))
    else $error("nonzero sum or max with zero count");

endmodule

// ----- design/tjs_ctrl.sv -----
module tjs_ctrl import tjs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts_i.count_nz) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
          step_d         = step_q + StepW'(1);
          if (step_q == StepW'(DivSteps - 1)) begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        step_d = '0;
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        step_d  = '0;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DIV && step_q == '0))
    else $error("accepted transaction did not start division");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (step_q == '0))
    else $error("step counter not cleared in idle");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_valid_q && state_q == S_IDLE))
    else $error("result load did not raise output valid");

endmodule

// ----- design/timer_jitter_statistics_unit.sv -----
// Channel | Signals                                   | Direction
// in      | in_valid_i, in_ready_o, in_data_i (in_t)  | command / lateness sample
// out     | out_valid_o, out_ready_i, out_data_o      | statistics snapshot (out_t)
//
// A sample first updates the accumulators, then runs through the bit-serial 64/32 mean
// divider, and is loaded into the output once the output register is free.
// A clear skips the divider. One transaction in flight at a time.
// The next input is taken while a result waits in the output register.
// Reset (async, active low) clears the statistics; no clearing pass.
module timer_jitter_statistics_unit import tjs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tjs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tjs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
